// ----- hw/rtl/encoder_speed_position_tracker_unit_macros.svh -----
// Assertion macros used by the encoder tracker datapath (espt_dp).
`ifndef ENCODER_SPEED_POSITION_TRACKER_UNIT_MACROS_SVH
`define ENCODER_SPEED_POSITION_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define ESPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define ESPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/espt_pkg.sv -----
// Types and constants of the encoder speed and position tracker.
`default_nettype none

package espt_pkg;

    localparam int CNT_W       = 32;
    localparam int SPEED_W     = 11;
    localparam int MAXC_W      = 15;
    localparam int DIR_W       = 4;
    localparam int FRUN_W      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_MAXC    = 4;
    localparam int TEN_W       = 19;
    localparam int DABS_W      = 19;
    localparam int DVD_W       = 29;
    localparam int DCNT_W      = 5;
    localparam int SUM_W       = 15;
    localparam int SMAG_W      = 14;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = 27;
    localparam int DIV10_SHIFT = 16;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_REVERSE = 3'd4;

    localparam logic [MAXC_W-1:0]       MAXC_RESET  = 15'd100;
    localparam logic signed [CNT_W-1:0] WRAP_HI     = 32'sd32767;
    localparam logic signed [CNT_W-1:0] WRAP_LO     = -32'sd32768;
    localparam logic signed [CNT_W-1:0] WRAP_SPAN   = 32'sd65536;
    localparam logic [FRUN_W-1:0]       FAULT_LIMIT = 4'd10;
    localparam logic [DVD_W-1:0]        SCALE_K     = 29'd1000;
    localparam logic [DVD_W-1:0]        SPEED_LIM   = 29'd1000;
    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 11'sd1000;
    localparam logic [RECIP_W-1:0]      DIV10_RECIP = 13'd6554;

    typedef struct packed {
        logic                    opcode;
        logic [1:0]              channel;
        logic signed [CNT_W-1:0] raw_count;
    } espt_in_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic signed [CNT_W-1:0]   position;
        logic                      fault;
    } espt_out_t;

    typedef struct packed {
        logic load;
        logic diff;
        logic check;
        logic apply;
        logic div_step;
        logic scale;
        logic mix;
        logic filt;
        logic out_load;
    } espt_cmd_t;

    typedef struct packed {
        logic take_div;
        logic div_last;
        logic out_free;
    } espt_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/espt_ctrl.sv -----
// Sequencing state machine of the encoder tracker.
`default_nettype none

module espt_ctrl
    import espt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  espt_stat_t      stat,
    output espt_cmd_t       cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIFF  = 9'b000000010,
        ST_CHECK = 9'b000000100,
        ST_APPLY = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_SCALE = 9'b000100000,
        ST_MIX   = 9'b001000000,
        ST_FILT  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:  state_next = ST_CHECK;
            ST_CHECK: state_next = ST_APPLY;
            ST_APPLY: state_next = stat.take_div ? ST_DIV : ST_DONE;
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_MIX;
            ST_MIX:   state_next = ST_FILT;
            ST_FILT:  state_next = ST_DONE;
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && s_valid;
        cmd.diff     = (state_reg == ST_DIFF);
        cmd.check    = (state_reg == ST_CHECK);
        cmd.apply    = (state_reg == ST_APPLY);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.scale    = (state_reg == ST_SCALE);
        cmd.mix      = (state_reg == ST_MIX);
        cmd.filt     = (state_reg == ST_FILT);
        cmd.out_load = (state_reg == ST_DONE) && stat.out_free;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/espt_dp.sv -----
// Datapath of the encoder tracker: channel state, divider, filter, result register.
`default_nettype none
`include "encoder_speed_position_tracker_unit_macros.svh"

module espt_dp
    import espt_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [MAXC_W-1:0]     cfg_wdata,
    input  espt_in_t                   s_data,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output espt_out_t                  m_data,
    input  espt_cmd_t                  cmd,
    output espt_stat_t                 stat
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [MAXC_W-1:0]         max_count_reg [NUM_MAXC];
    logic [DIR_W-1:0]          dir_reverse_reg;

    logic signed [CNT_W-1:0]   last_count_reg [NUM_CHANNELS];
    logic signed [CNT_W-1:0]   position_reg   [NUM_CHANNELS];
    logic [FRUN_W-1:0]         fault_run_reg  [NUM_CHANNELS];
    logic signed [SPEED_W-1:0] held_speed_reg [NUM_CHANNELS];
    logic signed [SPEED_W-1:0] filter_reg     [NUM_CHANNELS];

    espt_in_t                  item_reg;
    logic                      in_range_reg;
    logic signed [CNT_W-1:0]   d_reg;
    logic [MAXC_W-1:0]         m_reg;
    logic                      reject_reg;
    logic                      neg_reg;
    logic [DABS_W-1:0]         dabs_reg;
    logic [MAXC_W-1:0]         rem_reg;
    logic [DVD_W-1:0]          dvd_reg;
    logic [DCNT_W-1:0]         cnt_reg;
    logic signed [SPEED_W-1:0] spd_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      sum_neg_reg;
    espt_out_t                 res_reg;
    espt_out_t                 out_reg;
    logic                      m_valid_reg;

    logic [CH_W-1:0]           idx;
    logic signed [CNT_W-1:0]   last_cur;
    logic signed [CNT_W-1:0]   pos_cur;
    logic [FRUN_W-1:0]         frun_cur;
    logic signed [SPEED_W-1:0] held_cur;
    logic signed [SPEED_W-1:0] filter_cur;
    logic                      dir_bit;

    logic signed [CNT_W-1:0]   d_raw;
    logic signed [CNT_W-1:0]   d_fix;
    logic [MAXC_W-1:0]         maxc_sel;
    logic [MAXC_W-1:0]         m_eff;
    logic [CNT_W-1:0]          d_abs;
    logic [TEN_W-1:0]          ten_m;
    logic                      reject;

    logic signed [CNT_W-1:0]   pos_new;
    logic signed [CNT_W-1:0]   pos_rep_new;
    logic signed [CNT_W-1:0]   pos_rep_cur;
    logic [FRUN_W-1:0]         frun_inc;
    logic [DVD_W-1:0]          dvd_init;

    logic [MAXC_W:0]           trial;
    logic                      trial_ge;
    logic [MAXC_W:0]           trial_sub;

    logic signed [SPEED_W-1:0] s_mag;
    logic signed [SPEED_W-1:0] s_val;
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]          sum_abs;
    logic [SPEED_W-1:0]        f_mag;
    logic signed [SPEED_W-1:0] f_val;

    assign idx        = in_range_reg ? CH_W'(item_reg.channel) : '0;
    assign last_cur   = last_count_reg[idx];
    assign pos_cur    = position_reg[idx];
    assign frun_cur   = fault_run_reg[idx];
    assign held_cur   = held_speed_reg[idx];
    assign filter_cur = filter_reg[idx];
    assign dir_bit    = dir_reverse_reg[item_reg.channel];

    // difference with one 16-bit wrap correction
    assign d_raw = item_reg.raw_count - last_cur;
    always_comb begin
        if (d_raw > WRAP_HI) begin
            d_fix = d_raw - WRAP_SPAN;
        end else if (d_raw < WRAP_LO) begin
            d_fix = d_raw + WRAP_SPAN;
        end else begin
            d_fix = d_raw;
        end
    end

    assign maxc_sel = max_count_reg[item_reg.channel];
    assign m_eff    = (maxc_sel == '0) ? MAXC_W'(1) : maxc_sel;

    assign d_abs  = d_reg[CNT_W-1] ? CNT_W'(-d_reg) : CNT_W'(d_reg);
    assign ten_m  = (TEN_W'(m_reg) << 3) + (TEN_W'(m_reg) << 1);
    assign reject = d_abs > CNT_W'(ten_m);

    assign pos_new     = pos_cur + d_reg;
    assign pos_rep_new = dir_bit ? -pos_new : pos_new;
    assign pos_rep_cur = dir_bit ? -pos_cur : pos_cur;
    assign frun_inc    = frun_cur + FRUN_W'(1);
    assign dvd_init    = DVD_W'(dabs_reg) * SCALE_K;

    // restoring divider, one quotient bit per cycle
    assign trial     = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge  = trial >= {1'b0, m_reg};
    assign trial_sub = trial - {1'b0, m_reg};

    assign s_mag = (dvd_reg > SPEED_LIM) ? SPEED_MAX : $signed(SPEED_W'(dvd_reg));
    assign s_val = neg_reg ? -s_mag : s_mag;

    // 7*f + 3*s, then divide by ten through a reciprocal
    assign sum     = (SUM_W'(filter_cur) <<< 3) - SUM_W'(filter_cur)
                   + SUM_W'(spd_reg) + (SUM_W'(spd_reg) <<< 1);
    assign sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign f_mag   = prod_reg[PROD_W-1:DIV10_SHIFT];
    assign f_val   = sum_neg_reg ? -$signed(f_mag) : $signed(f_mag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_MAXC; i++) begin
                max_count_reg[i] <= MAXC_RESET;
            end
            dir_reverse_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                last_count_reg[c] <= '0;
                position_reg[c]   <= '0;
                fault_run_reg[c]  <= '0;
                held_speed_reg[c] <= '0;
                filter_reg[c]     <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index) inside
                    REG_MAX_COUNT0, REG_MAX_COUNT1, REG_MAX_COUNT2, REG_MAX_COUNT3: begin
                        max_count_reg[cfg_index[1:0]] <= cfg_wdata;
                    end
                    REG_DIR_REVERSE: dir_reverse_reg <= cfg_wdata[DIR_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.apply && in_range_reg) begin
                if (item_reg.opcode == OP_CLEAR) begin
                    last_count_reg[idx] <= '0;
                    position_reg[idx]   <= '0;
                end else if (reject_reg) begin
                    if (frun_inc > FAULT_LIMIT) begin
                        last_count_reg[idx] <= item_reg.raw_count;
                        fault_run_reg[idx]  <= '0;
                    end else begin
                        fault_run_reg[idx]  <= frun_inc;
                    end
                end else begin
                    last_count_reg[idx] <= item_reg.raw_count;
                    fault_run_reg[idx]  <= '0;
                    position_reg[idx]   <= pos_new;
                end
            end
            if (cmd.scale) begin
                held_speed_reg[idx] <= s_val;
            end
            if (cmd.filt) begin
                filter_reg[idx] <= f_val;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg     <= s_data;
            in_range_reg <= 32'(s_data.channel) < 32'(NUM_CHANNELS);
        end
        if (cmd.diff) begin
            d_reg <= d_fix;
            m_reg <= m_eff;
        end
        if (cmd.check) begin
            reject_reg <= reject;
            neg_reg    <= d_reg[CNT_W-1];
            dabs_reg   <= d_abs[DABS_W-1:0];
        end
        if (cmd.apply) begin
            rem_reg <= '0;
            dvd_reg <= dvd_init;
            cnt_reg <= DCNT_W'(DVD_W - 1);
            if (!in_range_reg || item_reg.opcode == OP_CLEAR) begin
                res_reg <= '0;
            end else if (reject_reg) begin
                res_reg.speed    <= held_cur;
                res_reg.position <= pos_rep_cur;
                res_reg.fault    <= 1'b1;
            end else begin
                res_reg.speed    <= '0;
                res_reg.position <= pos_rep_new;
                res_reg.fault    <= 1'b0;
            end
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_sub[MAXC_W-1:0] : trial[MAXC_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], trial_ge};
            cnt_reg <= cnt_reg - DCNT_W'(1);
        end
        if (cmd.scale) begin
            spd_reg <= s_val;
        end
        if (cmd.mix) begin
            sum_neg_reg <= sum[SUM_W-1];
            prod_reg    <= PROD_W'(sum_abs[SMAG_W-1:0]) * PROD_W'(DIV10_RECIP);
        end
        if (cmd.filt) begin
            res_reg.speed <= f_val;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign stat.take_div = in_range_reg && (item_reg.opcode == OP_SAMPLE) && !reject_reg;
    assign stat.div_last = (cnt_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `ESPT_ASSERT_IMP(a_rem_below_divisor, cmd.scale, rem_reg < m_reg, "divider remainder not below divisor")
    `ESPT_ASSERT_NEXT(a_filter_in_range, cmd.mix, f_mag <= SPEED_W'(SPEED_LIM), "filter quotient out of range")
    `ESPT_ASSERT_IMP(a_out_speed_range, m_valid_reg, (out_reg.speed <= SPEED_MAX) && (out_reg.speed >= -SPEED_MAX), "result speed out of range")

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_speed_position_tracker_unit.sv -----
// Top level of the four-channel encoder speed and position tracker.
//
// Input channel s_valid/s_ready/s_data carries one item per transfer: opcode
// (sample or clear), channel and the raw counter value. Result channel
// m_valid/m_ready/m_data returns exactly one result per input transfer, in order.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (max counts
// 0..3, direction bits 4) at the clock edge; write only while the block is idle.
// An accepted sample steps through the states DIFF, CHECK, APPLY, DIV, SCALE,
// MIX, FILT and DONE, and the block takes the next input transfer only once it
// is back in IDLE; DIV is the one-bit-per-cycle divider that scales the count
// difference to a speed. Clear, rejected and out-of-range items go from APPLY
// straight to DONE.
// While a result waits in the output register the block already takes and
// works on the next item; it holds the following result until m_ready frees
// the output register.
// Synchronous reset (aresetn low) clears all channel state, restores the
// configuration defaults and drops m_valid.
`default_nettype none

module encoder_speed_position_tracker_unit
    import espt_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAXC_W-1:0]    cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  espt_in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output espt_out_t                 m_data
);

    espt_cmd_t  cmd;
    espt_stat_t stat;

    espt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    espt_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ----- test/tb_encoder_speed_position_tracker_unit.sv -----
// Self-checking testbench for the encoder speed and position tracker (scoreboard against a model).
module tb_encoder_speed_position_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import espt_pkg::*;

    localparam int NUM_DIR        = 24;
    localparam int NUM_PHASES     = 6;
    localparam int RAND_PER_PHASE = 110;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        espt_in_t  item;
        bit        typed;
        espt_out_t want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAXC_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    espt_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    espt_out_t            m_data;

    // shadow of the block's configuration and per-channel state
    int                   max_cnt [4];
    logic [DIR_W-1:0]     dir_rev;
    logic [CNT_W-1:0]     cnt_prev [4];
    logic [CNT_W-1:0]     pos_acc [4];
    int                   rej_run [4];
    int                   held_spd [4];
    int                   smooth_spd [4];

    espt_out_t            pending_results [$];
    int                   errors = 0;
    int                   items_sent = 0;
    int                   clears_sent = 0;
    int                   results_seen = 0;
    int                   faults_seen = 0;
    int                   quiet_cycles = 0;
    int                   burst_left = 0;
    logic [1:0]           burst_ch = 2'd0;
    bit                   calm = 1'b0;
    bit                   hold_req = 1'b0;

    dir_row_t dir_rows [NUM_DIR] = '{
        '{'{OP_SAMPLE, 2'd0, 32'sd0},         1'b1, '{11'sd0, 32'sd0, 1'b0}},
        '{'{OP_SAMPLE, 2'd0, 32'sd1000},      1'b1, '{11'sd300, 32'sd1000, 1'b0}},
        '{'{OP_SAMPLE, 2'd0, 32'sd2001},      1'b1, '{11'sd1000, 32'sd1000, 1'b1}},
        '{'{OP_CLEAR,  2'd0, 32'sh7FFFFFFF},  1'b1, '{11'sd0, 32'sd0, 1'b0}},
        '{'{OP_SAMPLE, 2'd1, -32'sd1000},     1'b1, '{-11'sd300, -32'sd1000, 1'b0}},
        '{'{OP_SAMPLE, 2'd1, 32'sh80000000},  1'b1, '{-11'sd1000, -32'sd1000, 1'b1}},
        '{'{OP_SAMPLE, 2'd1, -32'sd2000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd3, 32'sd65530},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd3, 32'sd3},         1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sh7FFFFFFF},  1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50000},     1'b0, '0},
        '{'{OP_SAMPLE, 2'd2, 32'sd50010},     1'b0, '0},
        '{'{OP_CLEAR,  2'd3, 32'sd12345},     1'b1, '{11'sd0, 32'sd0, 1'b0}},
        '{'{OP_SAMPLE, 2'd3, -32'sd32768},    1'b0, '0},
        '{'{OP_SAMPLE, 2'd0, -32'sd1}, 1'b0, '0}
    };

    encoder_speed_position_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint eff_max(logic [1:0] ch);
        return (max_cnt[ch] == 0) ? 1 : max_cnt[ch];
    endfunction

    function automatic espt_out_t track_item(espt_in_t it);
        espt_out_t        res;
        logic [CNT_W-1:0] gap;
        logic [1:0]       ch;
        longint           d;
        longint           m;
        longint           spd;
        res = '0;
        ch  = it.channel;
        if (it.opcode == OP_CLEAR) begin
            cnt_prev[ch] = '0;
            pos_acc[ch]  = '0;
            return res;
        end
        gap = it.raw_count - cnt_prev[ch];
        d   = longint'(signed'(gap));
        if (d > WRAP_HI) begin
            d = d - WRAP_SPAN;
        end else if (d < WRAP_LO) begin
            d = d + WRAP_SPAN;
        end
        m = eff_max(ch);
        if (d > 10 * m || d < -(10 * m)) begin
            rej_run[ch] = (rej_run[ch] + 1) & 15;
            if (rej_run[ch] > FAULT_LIMIT) begin
                cnt_prev[ch] = it.raw_count;
                rej_run[ch]  = 0;
            end
            res.speed = held_spd[ch][SPEED_W-1:0];
            res.fault = 1'b1;
        end else begin
            rej_run[ch]  = 0;
            cnt_prev[ch] = it.raw_count;
            pos_acc[ch]  = pos_acc[ch] + d[CNT_W-1:0];
            spd = (d * 1000) / m;
            if (spd > SPEED_MAX) spd = SPEED_MAX;
            if (spd < -SPEED_MAX) spd = -SPEED_MAX;
            held_spd[ch]   = int'(spd);
            smooth_spd[ch] = int'((longint'(smooth_spd[ch]) * 7 + spd * 3) / 10);
            res.speed = smooth_spd[ch][SPEED_W-1:0];
        end
        res.position = dir_rev[ch] ? -pos_acc[ch] : pos_acc[ch];
        return res;
    endfunction

    // mostly plausible steps from the last accepted count, plus jumps, wraps and clears
    function automatic espt_in_t next_sample();
        espt_in_t it;
        int       r;
        int       lim;
        int       span;
        int       delta;
        it.opcode  = OP_SAMPLE;
        it.channel = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
            burst_left--;
            it.channel = burst_ch;
            r = 5;
        end else if (r < 5) begin
            it.opcode    = OP_CLEAR;
            it.raw_count = $urandom;
            return it;
        end else if (r < 8) begin
            burst_ch   = it.channel;
            burst_left = $urandom_range(10, 12);
            r = 5;
        end
        lim  = 10 * int'(eff_max(it.channel));
        span = (lim < 32767) ? lim : 32767;
        if (r < 8) begin
            if (lim >= 32767) begin
                delta = $urandom_range(0, 65535) - 32768;
            end else begin
                delta = $urandom_range(lim + 1, 32767);
                if ($urandom_range(0, 1)) delta = -delta;
            end
        end else if (r < 18) begin
            it.raw_count = $urandom;
            return it;
        end else if (r < 28) begin
            delta = $urandom_range(0, 2 * span) - span;
            delta = delta + ($urandom_range(0, 1) ? 65536 : -65536);
        end else if (r < 35) begin
            delta = span + $urandom_range(0, 1);
            if ($urandom_range(0, 1)) delta = -delta;
        end else begin
            delta = $urandom_range(0, 2 * span) - span;
        end
        it.raw_count = cnt_prev[it.channel] + delta;
        return it;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[MAXC_W-1:0];
        @(posedge aclk);
        if (idx <= REG_MAX_COUNT3) begin
            max_cnt[idx] = val & 32'h7FFF;
        end else if (idx == REG_DIR_REVERSE) begin
            dir_rev = val[DIR_W-1:0];
        end
    endtask

    task automatic send_item(input espt_in_t it, input bit typed, input espt_out_t want);
        espt_out_t got;
        s_valid <= 1'b1;
        s_data  <= it;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        got = track_item(it);
        pending_results.push_back(typed ? want : got);
        items_sent++;
        if (it.opcode == OP_CLEAR) clears_sent++;
    endtask

    task automatic idle_gap();
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    always @(negedge aclk) begin : result_check
        espt_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.fault) faults_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result speed %0d position %0d fault %0b",
                             $time, m_data.speed, m_data.position, m_data.fault);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_data.speed !== want.speed) begin
                        $display("%0t: speed mismatch, expected %0d, got %0d",
                                 $time, want.speed, m_data.speed);
                        errors++;
                    end
                    if (m_data.position !== want.position) begin
                        $display("%0t: position mismatch, expected %0d, got %0d",
                                 $time, want.position, m_data.position);
                        errors++;
                    end
                    if (m_data.fault !== want.fault) begin
                        $display("%0t: fault mismatch, expected %0b, got %0b",
                                 $time, want.fault, m_data.fault);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial begin : stimulus
        int k;
        int p;
        int vals [5];
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        for (k = 0; k < 4; k++) begin
            max_cnt[k]    = MAXC_RESET;
            cnt_prev[k]   = '0;
            pos_acc[k]    = '0;
            rej_run[k]    = 0;
            held_spd[k]   = 0;
            smooth_spd[k] = 0;
        end
        dir_rev = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < NUM_DIR; k++) begin
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
            idle_gap();
        end
        drain();

        for (p = 1; p <= NUM_PHASES; p++) begin
            case (p)
                1: vals = '{0, 0, 0, 0, 15};
                2: vals = '{32767, 32767, 32767, 32767, 0};
                3: vals = '{1, 32767, 100, 0, 10};
                default: begin
                    for (k = 0; k < 4; k++)
                        vals[k] = $urandom_range(0, 1) ? $urandom_range(1, 300)
                                                       : $urandom_range(0, 32767);
                    vals[4] = $urandom_range(0, 15);
                end
            endcase
            cfg_write(REG_MAX_COUNT0, vals[0]);
            cfg_write(REG_MAX_COUNT1, vals[1]);
            cfg_write(REG_MAX_COUNT2, vals[2]);
            cfg_write(REG_MAX_COUNT3, vals[3]);
            cfg_write(REG_DIR_REVERSE, vals[4]);
            if (p == 1) begin
                // unmapped indexes must not disturb anything
                for (k = int'(REG_DIR_REVERSE) + 1; k < (1 << CFG_IDX_W); k++)
                    cfg_write(CFG_IDX_W'(k), $urandom_range(0, 32767));
            end
            cfg_we <= 1'b0;
            calm     = (p == 3);
            hold_req = (p == 2) || (p == 5);
            for (k = 0; k < RAND_PER_PHASE; k++) begin
                send_item(next_sample(), 1'b0, '0);
                idle_gap();
            end
            drain();
            calm = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("Ran %0d items (%0d clears) over %0d register settings",
                 items_sent, clears_sent, NUM_PHASES + 1);
        $display("Checked %0d results, %0d of them rejected samples; %0d errors",
                 results_seen, faults_seen, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/espt_pkg.sv
hw/rtl/espt_ctrl.sv
hw/rtl/espt_dp.sv
hw/rtl/encoder_speed_position_tracker_unit.sv
test/tb_encoder_speed_position_tracker_unit.sv
